@@ sv/pse_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the postfix evaluator.
package pse_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int TOP_W    = 32;
  localparam int DEPTH_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_NUM = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MOD = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DIV_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ITER,
    ST_FINISH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                tok_load;
    logic                push;
    logic                alu_commit;
    logic                unit_load;
    logic                unit_step;
    logic                unit_commit;
    logic                stat_load;
    logic [STATUS_W-1:0] stat_code;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              lt_two;
    logic              div_zero;
    logic              iter_last;
  } flags_t;

endpackage

@@ sv/pse_datapath.sv @@
// Operand stack, top-of-stack register, shift-add/restoring arithmetic unit and result register.
module pse_datapath #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = pse_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pse_pkg::cmd_t                 cmd_i,
  output pse_pkg::flags_t               flags_o,
  input  logic [pse_pkg::KIND_W-1:0]    tok_kind_i,
  input  logic [pse_pkg::VALUE_W-1:0]   tok_value_i,
  output logic [pse_pkg::TOP_W-1:0]     top_value_o,
  output logic [pse_pkg::DEPTH_W-1:0]   depth_o,
  output logic [pse_pkg::STATUS_W-1:0]  status_o
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int ITER_W = $clog2(DATA_WIDTH);

  // The top entry lives in tos_q; the memory holds the entries below it.
  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

  logic [pse_pkg::KIND_W-1:0]   kind_q;
  logic [DATA_WIDTH-1:0]        value_q;
  logic [DATA_WIDTH-1:0]        rd_q;
  logic [DATA_WIDTH-1:0]        tos_q, tos_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [pse_pkg::STATUS_W-1:0] stat_q;
  logic [DATA_WIDTH-1:0]        x_q, x_d;
  logic [DATA_WIDTH-1:0]        y_q, y_d;
  logic [DATA_WIDTH-1:0]        acc_q, acc_d;
  logic                         na_q, nb_q;
  logic [ITER_W-1:0]            iter_q;
  logic [pse_pkg::TOP_W-1:0]    top_q;
  logic [pse_pkg::DEPTH_W-1:0]  depth_q;
  logic [pse_pkg::STATUS_W-1:0] ostat_q;

  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] alu_res, mag_a, mag_b, quot, rem_fix, rem_base, unit_res;
  logic [DATA_WIDTH:0]   shifted;
  logic                  ge;

  assign rd_addr = ADDR_W'(count_q - CNT_W'(2));
  assign wr_addr = ADDR_W'(count_q - CNT_W'(1));

  always_comb begin
    alu_res = (kind_q == pse_pkg::KIND_ADD) ? rd_q + tos_q : rd_q - tos_q;
    mag_a   = rd_q[DATA_WIDTH-1] ? -rd_q : rd_q;
    mag_b   = tos_q[DATA_WIDTH-1] ? -tos_q : tos_q;

    x_d   = x_q;
    y_d   = y_q;
    acc_d = acc_q;
    shifted = {acc_q, x_q[DATA_WIDTH-1]};
    ge      = shifted >= {1'b0, y_q};
    if (kind_q == pse_pkg::KIND_MUL) begin
      acc_d = acc_q + (x_q[0] ? y_q : '0);
      x_d   = x_q >> 1;
      y_d   = y_q << 1;
    end else begin
      acc_d = ge ? DATA_WIDTH'(shifted - {1'b0, y_q}) : shifted[DATA_WIDTH-1:0];
      x_d   = {x_q[DATA_WIDTH-2:0], ge};
    end

    quot = (na_q ^ nb_q) ? -x_q : x_q;
    // Floored modulo: the nonzero remainder is moved to the divisor's sign.
    rem_base = (na_q ^ nb_q) ? tos_q : '0;
    rem_fix  = na_q ? rem_base - acc_q : rem_base + acc_q;
    if (acc_q == '0) begin
      rem_fix = '0;
    end

    case (kind_q)
      pse_pkg::KIND_MUL: unit_res = acc_q;
      pse_pkg::KIND_DIV: unit_res = quot;
      default:           unit_res = rem_fix;
    endcase

    tos_d   = tos_q;
    count_d = count_q;
    if (cmd_i.push) begin
      tos_d   = value_q;
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.alu_commit) begin
      tos_d   = alu_res;
      count_d = count_q - CNT_W'(1);
    end else if (cmd_i.unit_commit) begin
      tos_d   = unit_res;
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && count_q != '0) begin
      mem[wr_addr] <= tos_q;
    end
    if (cmd_i.tok_load) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (cmd_i.tok_load) begin
      kind_q  <= tok_kind_i;
      value_q <= DATA_WIDTH'($signed(tok_value_i));
    end
    if (cmd_i.stat_load) begin
      stat_q <= cmd_i.stat_code;
    end
    if (cmd_i.unit_load) begin
      iter_q <= ITER_W'(DATA_WIDTH - 1);
      acc_q  <= '0;
      na_q   <= rd_q[DATA_WIDTH-1];
      nb_q   <= tos_q[DATA_WIDTH-1];
      if (kind_q == pse_pkg::KIND_MUL) begin
        x_q <= tos_q;
        y_q <= rd_q;
      end else begin
        x_q <= mag_a;
        y_q <= mag_b;
      end
    end else if (cmd_i.unit_step) begin
      iter_q <= iter_q - ITER_W'(1);
      x_q    <= x_d;
      y_q    <= y_d;
      acc_q  <= acc_d;
    end
    if (cmd_i.out_load) begin
      top_q   <= (count_q == '0) ? '0 : pse_pkg::TOP_W'($signed(tos_q));
      depth_q <= pse_pkg::DEPTH_W'(count_q);
      ostat_q <= stat_q;
    end
  end

  assign flags_o.kind      = kind_q;
  assign flags_o.full      = count_q == CNT_W'(STACK_DEPTH);
  assign flags_o.lt_two    = count_q < CNT_W'(2);
  assign flags_o.div_zero  = tos_q == '0;
  assign flags_o.iter_last = iter_q == '0;

  assign top_value_o = top_q;
  assign depth_o     = depth_q;
  assign status_o    = ostat_q;

endmodule

@@ sv/pse_ctrl.sv @@
// Token sequencer: decodes each token and drives the datapath and the output handshake.
module pse_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pse_pkg::flags_t flags_i,
  output pse_pkg::cmd_t   cmd_o
);

  pse_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pse_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      pse_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.tok_load = 1'b1;
          state_d        = pse_pkg::ST_DECODE;
        end
      end
      pse_pkg::ST_DECODE: begin
        cmd_o.stat_load = 1'b1;
        cmd_o.stat_code = pse_pkg::STAT_OK;
        state_d         = pse_pkg::ST_DONE;
        case (flags_i.kind)
          pse_pkg::KIND_NUM: begin
            if (flags_i.full) begin
              cmd_o.stat_code = pse_pkg::STAT_OVERFLOW;
            end else begin
              cmd_o.push = 1'b1;
            end
          end
          pse_pkg::KIND_ADD, pse_pkg::KIND_SUB: begin
            if (flags_i.lt_two) begin
              cmd_o.stat_code = pse_pkg::STAT_UNDERFLOW;
            end else begin
              cmd_o.alu_commit = 1'b1;
            end
          end
          pse_pkg::KIND_MUL: begin
            if (flags_i.lt_two) begin
              cmd_o.stat_code = pse_pkg::STAT_UNDERFLOW;
            end else begin
              cmd_o.unit_load = 1'b1;
              state_d         = pse_pkg::ST_ITER;
            end
          end
          pse_pkg::KIND_DIV, pse_pkg::KIND_MOD: begin
            if (flags_i.lt_two) begin
              cmd_o.stat_code = pse_pkg::STAT_UNDERFLOW;
            end else if (flags_i.div_zero) begin
              cmd_o.stat_code = pse_pkg::STAT_DIV_ZERO;
            end else begin
              cmd_o.unit_load = 1'b1;
              state_d         = pse_pkg::ST_ITER;
            end
          end
          default: begin
            // Unknown kinds leave the stack alone and report ok.
          end
        endcase
      end
      pse_pkg::ST_ITER: begin
        cmd_o.unit_step = 1'b1;
        if (flags_i.iter_last) begin
          state_d = pse_pkg::ST_FINISH;
        end
      end
      pse_pkg::ST_FINISH: begin
        cmd_o.unit_commit = 1'b1;
        state_d           = pse_pkg::ST_DONE;
      end
      pse_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = pse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pse_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/postfix_stack_evaluator.sv @@
// Push, add, subtract, ignored kinds and all errors go from the sequencer's decode state
// straight to its done state; multiply, divide and modulo pass through its iterate and finish
// states in between, run by the one-bit-per-cycle shift-add / restoring unit. One token is in
// work at a time, so a new token is taken only once the last has been loaded into the output
// register, which lets it enter while the previous result still waits. Reset clears the depth,
// the sequencer and the output valid; stack contents are not cleared.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = pse_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] value
  input  logic [2:0]  s_axis_tuser,  // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] top_value, [36:32] depth, [38:37] status
);

  pse_pkg::cmd_t                cmd;
  pse_pkg::flags_t              flags;
  logic [pse_pkg::TOP_W-1:0]    top_value;
  logic [pse_pkg::DEPTH_W-1:0]  depth;
  logic [pse_pkg::STATUS_W-1:0] status;

  pse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .flags_o     (flags),
    .tok_kind_i  (s_axis_tuser),
    .tok_value_i (s_axis_tdata),
    .top_value_o (top_value),
    .depth_o     (depth),
    .status_o    (status)
  );

  assign m_axis_tdata = {1'b0, status, depth, top_value};

endmodule

@@ sv/pse_checker.sv @@
// Port-level checks of the postfix evaluator, bound to its top level.
module pse_checker #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  localparam logic SMALL_STACK = STACK_DEPTH < 32;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second token taken while one is in work");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[38:37] == pse_pkg::STAT_OVERFLOW
      |-> m_axis_tdata[36:32] == 5'(STACK_DEPTH))
    else $error("overflow reported below full depth");

  a_underflow_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SMALL_STACK && m_axis_tvalid && m_axis_tdata[38:37] == pse_pkg::STAT_UNDERFLOW
      |-> m_axis_tdata[36:32] < 5'd2)
    else $error("underflow reported with two or more operands");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SMALL_STACK && m_axis_tvalid && m_axis_tdata[36:32] == 5'd0
      |-> m_axis_tdata[31:0] == 32'd0)
    else $error("empty stack shows a nonzero top");

endmodule

bind postfix_stack_evaluator pse_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_pse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
